[hdl/kpc_pkg.sv]
// Shared types and constants for the key press classifier.
package kpc_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ThrW    = 16;

  localparam logic [CfgIdxW-1:0] CFG_ACTIVE_LOW     = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE       = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS     = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_REPEAT_MS = 8'd3;

  localparam logic            RST_ACTIVE_LOW     = 1'b1;
  localparam logic [ThrW-1:0] RST_DEBOUNCE       = 16'd10;
  localparam logic [ThrW-1:0] RST_LONG_PRESS     = 16'd1500;
  localparam logic [ThrW-1:0] RST_HOLD_REPEAT_MS = 16'd500;

  typedef struct packed {
    logic            active_low;
    logic [ThrW-1:0] debounce_thr;
    logic [ThrW-1:0] long_thr;
    logic [ThrW-1:0] hold_repeat_ms;
  } cfg_t;

  typedef struct packed {
    logic             short_press;
    logic             long_press;
    logic             long_hold;
    logic             pressed;
    logic [TimeW-1:0] press_time_ms;
  } res_t;

endpackage

[hdl/kpc_cfg.sv]
// Configuration register file of the key press classifier.
module kpc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [kpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kpc_pkg::ThrW-1:0]     cfg_data_i,
  output kpc_pkg::cfg_t                cfg_o
);

  kpc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kpc_pkg::CFG_ACTIVE_LOW:     cfg_d.active_low     = cfg_data_i[0];
        kpc_pkg::CFG_DEBOUNCE:       cfg_d.debounce_thr   = cfg_data_i;
        kpc_pkg::CFG_LONG_PRESS:     cfg_d.long_thr       = cfg_data_i;
        kpc_pkg::CFG_HOLD_REPEAT_MS: cfg_d.hold_repeat_ms = cfg_data_i;
        default:                     cfg_d = cfg_q; // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low     <= kpc_pkg::RST_ACTIVE_LOW;
      cfg_q.debounce_thr   <= kpc_pkg::RST_DEBOUNCE;
      cfg_q.long_thr       <= kpc_pkg::RST_LONG_PRESS;
      cfg_q.hold_repeat_ms <= kpc_pkg::RST_HOLD_REPEAT_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/kpc_fsm.sv]
// Press state machine and timing datapath; computes one result per step.
module kpc_fsm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      cmd_i,
  input  logic                      pin_level_i,
  input  logic [kpc_pkg::TimeW-1:0] now_ms_i,
  input  kpc_pkg::cfg_t             cfg_i,
  output kpc_pkg::res_t             res_o
);

  typedef enum logic [2:0] {
    ModeIdle      = 3'd0,
    ModePressDb   = 3'd1,
    ModePressed   = 3'd2,
    ModeLong      = 3'd3,
    ModeReleaseDb = 3'd4
  } mode_e;

  mode_e                     mode_q, mode_d;
  logic [kpc_pkg::TimeW-1:0] press_start_q, press_start_d;
  logic [kpc_pkg::TimeW-1:0] held_time_q, held_time_d;
  logic [kpc_pkg::TimeW-1:0] hold_mark_q, hold_mark_d;

  logic                      act;
  logic [kpc_pkg::TimeW-1:0] since_start;
  logic [kpc_pkg::TimeW-1:0] since_hold;
  logic [kpc_pkg::TimeW-1:0] since_release;
  logic [kpc_pkg::TimeW-1:0] deb_w, long_w, rep_w;
  kpc_pkg::res_t             res;

  assign deb_w  = {{(kpc_pkg::TimeW-kpc_pkg::ThrW){1'b0}}, cfg_i.debounce_thr};
  assign long_w = {{(kpc_pkg::TimeW-kpc_pkg::ThrW){1'b0}}, cfg_i.long_thr};
  assign rep_w  = {{(kpc_pkg::TimeW-kpc_pkg::ThrW){1'b0}}, cfg_i.hold_repeat_ms};

  assign act           = cfg_i.active_low ? !pin_level_i : pin_level_i;
  assign since_start   = now_ms_i - press_start_q;
  assign since_hold    = since_start - hold_mark_q;
  assign since_release = now_ms_i - (press_start_q + held_time_q);

  always_comb begin
    mode_d        = mode_q;
    press_start_d = press_start_q;
    held_time_d   = held_time_q;
    hold_mark_d   = hold_mark_q;
    res           = '0;

    if (cmd_i) begin
      mode_d      = ModeIdle;
      hold_mark_d = '0;
    end else begin
      unique case (mode_q)
        ModeIdle: begin
          if (act) begin
            mode_d        = ModePressDb;
            press_start_d = now_ms_i;
            held_time_d   = '0;
          end
        end
        ModePressDb: begin
          if (!act) begin
            mode_d = ModeIdle;
          end else if (since_start >= deb_w) begin
            mode_d = ModePressed;
          end
        end
        ModePressed: begin
          if (!act) begin
            mode_d = ModeReleaseDb;
          end else begin
            held_time_d = since_start;
            if (since_start >= long_w) begin
              res.long_press = 1'b1;
              mode_d         = ModeLong;
            end
          end
        end
        ModeLong: begin
          if (!act) begin
            mode_d = ModeReleaseDb;
          end else begin
            held_time_d = since_start;
            if (since_hold >= rep_w) begin
              res.long_hold = 1'b1;
              hold_mark_d   = since_start;
            end
          end
        end
        ModeReleaseDb: begin
          if (act) begin
            mode_d = ModePressed;
          end else if (since_release >= deb_w) begin
            res.short_press = (held_time_q < long_w);
            mode_d          = ModeIdle;
            hold_mark_d     = '0;
          end
        end
        default: mode_d = ModeIdle;
      endcase
      res.pressed       = (mode_d == ModePressed) || (mode_d == ModeLong);
      // press duration reads against the start as updated by this beat
      res.press_time_ms = act ? (now_ms_i - press_start_d) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= ModeIdle;
      press_start_q <= '0;
      held_time_q   <= '0;
      hold_mark_q   <= '0;
    end else if (step_i) begin
      mode_q        <= mode_d;
      press_start_q <= press_start_d;
      held_time_q   <= held_time_d;
      hold_mark_q   <= hold_mark_d;
    end
  end

  assign res_o = res;

endmodule

[hdl/key_press_classifier.sv]
// Top level: input register, press state machine, result register, config port.
//
//   channel | direction | payload                                   | handshake
//   in      | in        | cmd, pin_level, now_ms                    | in_valid_i / in_ready_o
//   out     | out       | short_press, long_press, long_hold,       | out_valid_o / out_ready_i
//           |           | pressed, press_time_ms                    |
//   cfg     | in        | cfg_index (8b), cfg_data (16b)            | cfg_valid_i / cfg_ready_o
//
// One beat per cycle sustained while out_ready_i is high; a beat goes through the
// input register, then the state machine step into the result register, where its
// result sits on the outputs until out_ready_i takes it.
// The state machine updates its state as the beat moves into the result register.
// A stalled result holds in its register; one more beat waits in the input register
// and in_ready_o drops until the result leaves. Reset idles the state machine, clears the
// valid flags and loads config defaults (data registers unreset); cfg_ready_o is always high.
module key_press_classifier (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic                        pin_level_i,
  input  logic [31:0]                 now_ms_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        short_press_o,
  output logic                        long_press_o,
  output logic                        long_hold_o,
  output logic                        pressed_o,
  output logic [31:0]                 press_time_ms_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [kpc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [kpc_pkg::ThrW-1:0]    cfg_data_i
);

  logic                      in_vld_q, in_vld_d;
  logic                      cmd_q;
  logic                      pin_q;
  logic [kpc_pkg::TimeW-1:0] now_q;
  logic                      out_vld_q, out_vld_d;
  kpc_pkg::res_t             res_q;
  kpc_pkg::res_t             res;
  kpc_pkg::cfg_t             cfg;
  logic                      advance;
  logic                      in_take;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  assign in_vld_d  = in_take || (in_vld_q && !advance);
  assign out_vld_d = advance || (out_vld_q && !out_ready_i);

  assign cfg_ready_o = 1'b1;

  kpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kpc_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .cmd_i       (cmd_q),
    .pin_level_i (pin_q),
    .now_ms_i    (now_q),
    .cfg_i       (cfg),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_i;
      pin_q <= pin_level_i;
      now_q <= now_ms_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign short_press_o   = res_q.short_press;
  assign long_press_o    = res_q.long_press;
  assign long_hold_o     = res_q.long_hold;
  assign pressed_o       = res_q.pressed;
  assign press_time_ms_o = res_q.press_time_ms;

endmodule
